/* rtl/bpsc_pkg.sv */
// Shared types and constants for the button press sequence classifier.
// Used by the controller, the datapath, the top level and the checker.
package bpsc_pkg;

  localparam int MAX_SYMBOLS = 16;
  localparam int SYM_IDX_W   = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int SYM_CNT_W   = $clog2(MAX_SYMBOLS + 1);

  localparam int CNT_W  = 17;
  localparam int CFG_W  = 16;
  localparam int SEQ_W  = 5;
  localparam int IDX_W  = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [CFG_W-1:0] LONG_RESET  = 16'd300;
  localparam logic [CFG_W-1:0] SHORT_RESET = 16'd1;
  localparam logic [CFG_W-1:0] IDLE_RESET  = 16'd40;

  localparam logic [IDX_W-1:0] CFG_LONG  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_SHORT = 2'd1;
  localparam logic [IDX_W-1:0] CFG_IDLE  = 2'd2;

  typedef enum logic [1:0] {
    KIND_SHORT = 2'd0,
    KIND_LONG  = 2'd1,
    KIND_CLICK = 2'd2,
    KIND_SEQ   = 2'd3
  } bpsc_kind_t;

  typedef struct packed {
    logic       take;       // latch the accepted button sample
    logic       seq_start;  // reset the store read index
    logic       seq_next;   // advance the store read index
    logic       load;       // load the output register
    bpsc_kind_t kind;
    logic       last;
    logic       step;       // commit the state update of this item
  } bpsc_cmd_t;

  typedef struct packed {
    logic held;
    logic rel_edge;
    logic rel_idle;
    logic hit_short;
    logic hit_long;
    logic click;
    logic seq_due;
    logic seq_last;
    logic out_free;
  } bpsc_status_t;

endpackage

/* rtl/bpsc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bpsc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/bpsc_datapath.sv */
// Datapath: configuration registers, hold and idle counters, symbol store
// and output register. Depends on bpsc_pkg and bpsc_ram.
module bpsc_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic [bpsc_pkg::IDX_W-1:0] cfg_index,
  input  logic [bpsc_pkg::CFG_W-1:0] cfg_data,
  input  logic                      button_level,
  input  logic                      out_ready,
  input  bpsc_pkg::bpsc_cmd_t       cmd,
  output bpsc_pkg::bpsc_status_t    status,
  output logic                      out_valid,
  output logic [1:0]                event_kind,
  output logic                      symbol,
  output logic [bpsc_pkg::SEQ_W-1:0] sequence_count,
  output logic                      last
);
  import bpsc_pkg::*;

  logic [CFG_W-1:0]     long_ticks;
  logic [CFG_W-1:0]     short_ticks;
  logic [CFG_W-1:0]     idle_ticks;
  logic                 level;
  logic                 prev_level;
  logic [CNT_W-1:0]     hold_cnt;
  logic [CNT_W-1:0]     idle_cnt;
  logic [SYM_CNT_W-1:0] sym_count;
  logic [SYM_CNT_W-1:0] rd_idx;
  logic                 store_we;
  logic                 store_rdata;
  logic                 dash;
  logic                 store_room;
  logic                 out_sym_next;

  assign dash       = hold_cnt > CNT_W'(long_ticks);
  assign store_room = sym_count < SYM_CNT_W'(MAX_SYMBOLS);

  always_comb begin
    status.held      = level & prev_level;
    status.rel_edge  = ~level & prev_level;
    status.rel_idle  = ~level & ~prev_level;
    status.hit_short = hold_cnt == CNT_W'(short_ticks);
    status.hit_long  = hold_cnt == CNT_W'(long_ticks);
    status.click     = dash | (hold_cnt > CNT_W'(short_ticks));
    status.seq_due   = (sym_count != '0) && (idle_cnt > CNT_W'(idle_ticks));
    status.seq_last  = (rd_idx + SYM_CNT_W'(1)) == sym_count;
    status.out_free  = ~out_valid | out_ready;
  end

  // A classified press is stored at the next free slot while there is room.
  assign store_we = cmd.step & status.rel_edge & status.click & store_room;

  bpsc_ram #(.WIDTH(1), .DEPTH(MAX_SYMBOLS)) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (sym_count[SYM_IDX_W-1:0]),
    .wdata (dash),
    .raddr (rd_idx[SYM_IDX_W-1:0]),
    .rdata (store_rdata)
  );

  always_comb begin
    case (cmd.kind)
      KIND_CLICK: out_sym_next = dash;
      KIND_SEQ:   out_sym_next = store_rdata;
      default:    out_sym_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      long_ticks  <= LONG_RESET;
      short_ticks <= SHORT_RESET;
      idle_ticks  <= IDLE_RESET;
      prev_level  <= 1'b0;
      hold_cnt    <= '0;
      idle_cnt    <= '0;
      sym_count   <= '0;
      rd_idx      <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_LONG:  long_ticks  <= cfg_data;
          CFG_SHORT: short_ticks <= cfg_data;
          CFG_IDLE:  idle_ticks  <= cfg_data;
          default:   ;
        endcase
      end

      if (cmd.seq_start) begin
        rd_idx <= '0;
      end else if (cmd.seq_next) begin
        rd_idx <= rd_idx + SYM_CNT_W'(1);
      end

      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cmd.step) begin
        prev_level <= level;
        if (status.rel_idle) begin
          if (sym_count != '0) begin
            if (idle_cnt > CNT_W'(idle_ticks)) begin
              sym_count <= '0;
              idle_cnt  <= '0;
            end else if (idle_cnt != CNT_MAX) begin
              idle_cnt <= idle_cnt + CNT_W'(1);
            end
          end else begin
            idle_cnt <= '0;
          end
        end else if (status.held) begin
          if (hold_cnt != CNT_MAX) begin
            hold_cnt <= hold_cnt + CNT_W'(1);
          end
        end else if (status.rel_edge) begin
          if (status.click && store_room) begin
            sym_count <= sym_count + SYM_CNT_W'(1);
          end
          idle_cnt <= '0;
        end else begin
          hold_cnt <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      level <= button_level;
    end
    if (cmd.load) begin
      event_kind     <= cmd.kind;
      symbol         <= out_sym_next;
      sequence_count <= (cmd.kind == KIND_SEQ) ? SEQ_W'(sym_count) : '0;
      last           <= cmd.last;
    end
  end

endmodule

/* rtl/bpsc_ctrl.sv */
// Controller: sequences evaluation, result emission and state update of
// one item at a time. Depends on bpsc_pkg.
module bpsc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  bpsc_pkg::bpsc_status_t status,
  output bpsc_pkg::bpsc_cmd_t    cmd
);
  import bpsc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SHORT,
    S_LONG,
    S_CLICK,
    S_SEQ_RD,
    S_SEQ_OUT,
    S_STEP
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    cmd = '0;
    cmd.kind = KIND_SHORT;
    unique case (state)
      S_IDLE:  cmd.take = in_valid;
      S_EVAL:  cmd.seq_start = 1'b1;
      S_SHORT: begin
        cmd.load = status.out_free;
        cmd.kind = KIND_SHORT;
        cmd.last = ~status.hit_long;
      end
      S_LONG: begin
        cmd.load = status.out_free;
        cmd.kind = KIND_LONG;
        cmd.last = 1'b1;
      end
      S_CLICK: begin
        cmd.load = status.out_free;
        cmd.kind = KIND_CLICK;
        cmd.last = 1'b1;
      end
      S_SEQ_RD: ;
      S_SEQ_OUT: begin
        cmd.load     = status.out_free;
        cmd.seq_next = status.out_free;
        cmd.kind     = KIND_SEQ;
        cmd.last     = status.seq_last;
      end
      S_STEP:  cmd.step = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_EVAL;
        end
        S_EVAL: begin
          if (status.held && status.hit_short) begin
            state <= S_SHORT;
          end else if (status.held && status.hit_long) begin
            state <= S_LONG;
          end else if (status.rel_edge && status.click) begin
            state <= S_CLICK;
          end else if (status.rel_idle && status.seq_due) begin
            state <= S_SEQ_RD;
          end else begin
            state <= S_STEP;
          end
        end
        S_SHORT: begin
          if (status.out_free) state <= status.hit_long ? S_LONG : S_STEP;
        end
        S_LONG, S_CLICK: begin
          if (status.out_free) state <= S_STEP;
        end
        S_SEQ_RD: state <= S_SEQ_OUT;
        S_SEQ_OUT: begin
          if (status.out_free) state <= status.seq_last ? S_STEP : S_SEQ_RD;
        end
        S_STEP: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/button_press_sequence_classifier_unit.sv */
// Button press sequence classifier: one button sample per item in, press
// events, clicks and ended symbol sequences out. An item is evaluated the
// cycle after acceptance; a short, long or click result is then loaded when the
// output is free, and each stored symbol of an ended sequence is read from the
// store, then loaded into the output register, before the state update.
// Synchronous reset loads thresholds 300/1/40 and clears counters and output.
module button_press_sequence_classifier_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bpsc_pkg::IDX_W-1:0] cfg_index,
  input  logic [bpsc_pkg::CFG_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       button_level,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 event_kind,
  output logic                       symbol,
  output logic [bpsc_pkg::SEQ_W-1:0] sequence_count,
  output logic                       last
);
  import bpsc_pkg::*;

  bpsc_cmd_t    cmd;
  bpsc_status_t status;

  assign cfg_ready = ~rst;

  bpsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  bpsc_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .button_level   (button_level),
    .out_ready      (out_ready),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .event_kind     (event_kind),
    .symbol         (symbol),
    .sequence_count (sequence_count),
    .last           (last)
  );

endmodule

/* rtl/bpsc_checker.sv */
// Port-level checks for the button press sequence classifier, bound to
// the top level. Depends on bpsc_pkg.
module bpsc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [1:0]                 event_kind,
  input logic                       symbol,
  input logic [bpsc_pkg::SEQ_W-1:0] sequence_count,
  input logic                       last
);
  import bpsc_pkg::*;

  // A waiting result holds until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_kind) && $stable(symbol)
      && $stable(sequence_count) && $stable(last))
    else $error("stalled result changed");

  // Items are worked one at a time: no acceptance right after another.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in work");

  // A sequence symbol always carries a nonzero count within capacity.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == KIND_SEQ |->
      sequence_count != '0 && sequence_count <= SEQ_W'(MAX_SYMBOLS))
    else $error("bad sequence count");

  // Threshold events carry no symbol and no count.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == KIND_SHORT || event_kind == KIND_LONG) |->
      !symbol && sequence_count == '0)
    else $error("threshold event with payload");

endmodule

bind button_press_sequence_classifier_unit bpsc_checker u_bpsc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .event_kind     (event_kind),
  .symbol         (symbol),
  .sequence_count (sequence_count),
  .last           (last)
);

/* test/tb_button_press_sequence_classifier_unit.sv */
// Self-checking testbench for button_press_sequence_classifier_unit: press, hold and
// release patterns go in, and each press event, click and ended sequence is checked.
// Depends on bpsc_pkg and the classifier top level with its submodules and checker.
module tb_button_press_sequence_classifier_unit;
  import bpsc_pkg::*;

  localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    bpsc_kind_t       kind;
    logic             sym;
    logic [SEQ_W-1:0] count;
    logic             last;
  } press_event_t;

  // Tracks the classifier state and holds the results it should produce.
  class press_scoreboard;
    logic [CFG_W-1:0] long_ticks;
    logic [CFG_W-1:0] short_ticks;
    logic [CFG_W-1:0] idle_limit;
    logic             prev_level;
    logic [CNT_W-1:0] hold_cnt;
    logic [CNT_W-1:0] idle_cnt;
    int               sym_count;
    logic             sym_store [MAX_SYMBOLS];
    press_event_t     expected [$];
    int               errors;
    int               levels_taken;
    int               results_seen;
    int               kind_seen [4];
    int               full_drops;

    function new();
      long_ticks   = LONG_RESET;
      short_ticks  = SHORT_RESET;
      idle_limit   = IDLE_RESET;
      prev_level   = 1'b0;
      hold_cnt     = '0;
      idle_cnt     = '0;
      sym_count    = 0;
      errors       = 0;
      levels_taken = 0;
      results_seen = 0;
      full_drops   = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
    endfunction

    function void note_config(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_LONG:  long_ticks  = val;
        CFG_SHORT: short_ticks = val;
        CFG_IDLE:  idle_limit  = val;
        default: ;
      endcase
    endfunction

    function void note_level(logic lvl);
      press_event_t batch [$];
      logic         have;
      logic         sym;
      have = 1'b0;
      sym  = 1'b0;
      levels_taken++;
      if (!lvl && !prev_level) begin
        if (sym_count > 0) begin
          if (idle_cnt > idle_limit) begin
            for (int i = 0; i < sym_count; i++)
              batch.push_back('{kind: KIND_SEQ, sym: sym_store[i],
                                count: SEQ_W'(sym_count), last: 1'b0});
            sym_count = 0;
            idle_cnt  = '0;
          end else if (idle_cnt != CNT_MAX) begin
            idle_cnt++;
          end
        end else begin
          idle_cnt = '0;
        end
      end else if (lvl && !prev_level) begin
        hold_cnt = '0;
      end else if (lvl && prev_level) begin
        if (hold_cnt == {1'b0, short_ticks})
          batch.push_back('{kind: KIND_SHORT, sym: 1'b0, count: '0, last: 1'b0});
        if (hold_cnt == {1'b0, long_ticks})
          batch.push_back('{kind: KIND_LONG, sym: 1'b0, count: '0, last: 1'b0});
        if (hold_cnt != CNT_MAX) hold_cnt++;
      end else begin
        if (hold_cnt > {1'b0, long_ticks}) begin
          have = 1'b1;
          sym  = 1'b1;
        end else if (hold_cnt > {1'b0, short_ticks}) begin
          have = 1'b1;
        end
        if (have) begin
          batch.push_back('{kind: KIND_CLICK, sym: sym, count: '0, last: 1'b0});
          if (sym_count < MAX_SYMBOLS) begin
            sym_store[sym_count] = sym;
            sym_count++;
          end else begin
            full_drops++;
          end
        end
        idle_cnt = '0;
      end
      prev_level = lvl;
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[i]) expected.push_back(batch[i]);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [1:0] kind, logic sym, logic [SEQ_W-1:0] count,
                               logic lst);
      press_event_t want;
      results_seen++;
      if (expected.size() == 0) begin
        errors++;
        $display(
          "%0t: extra result, expected none, got kind %0d symbol %0d count %0d last %0d",
          $time, kind, sym, count, lst);
        return;
      end
      want = expected.pop_front();
      kind_seen[want.kind]++;
      compare_field("event_kind", want.kind, kind);
      compare_field("symbol", want.sym, sym);
      compare_field("sequence_count", want.count, count);
      compare_field("last", want.last, lst);
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             button_level = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [1:0]       event_kind;
  logic             symbol;
  logic [SEQ_W-1:0] sequence_count;
  logic             last;

  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  bit long_stall_req = 1'b0;
  bit long_stall_done = 1'b0;
  int ready_hold = 0;

  press_scoreboard book = new();

  button_press_sequence_classifier_unit dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .button_level   (button_level),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_kind     (event_kind),
    .symbol         (symbol),
    .sequence_count (sequence_count),
    .last           (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: checks every result taken and drives out_ready in bursts.
  always @(posedge clk) begin
    if (out_valid && out_ready)
      book.check_result(event_kind, symbol, sequence_count, last);
    if (rst) begin
      out_ready <= 1'b0;
    end else if (ready_hold > 0) begin
      ready_hold--;
    end else if (long_stall_req && !long_stall_done) begin
      long_stall_done = 1'b1;
      ready_hold = 400;
      out_ready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 2) == 0) begin
      ready_hold = $urandom_range(0, 10);
      out_ready <= 1'b0;
    end else begin
      ready_hold = $urandom_range(0, 15);
      out_ready <= 1'b1;
    end
  end

  task automatic send_level(input logic lvl);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    button_level <= lvl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.note_level(lvl);
  endtask

  task automatic send_run(input logic lvl, input int count);
    repeat (count) send_level(lvl);
  endtask

  // Items that cause no result may still be in flight once the queue is empty.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    book.note_config(idx, val);
  endtask

  task automatic set_thresholds(input logic [CFG_W-1:0] long_val,
                                input logic [CFG_W-1:0] short_val,
                                input logic [CFG_W-1:0] idle_val);
    wait_drained();
    write_reg(CFG_UNUSED, CFG_W'($urandom));
    write_reg(CFG_LONG, long_val);
    write_reg(CFG_SHORT, short_val);
    write_reg(CFG_IDLE, idle_val);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed press, hold, release gestures, with some random samples mixed in.
  // end_odds sets how often a release gap is long enough to end the sequence.
  task automatic random_gestures(input int n_items, input int end_odds);
    int sent;
    int hold;
    int gap;
    int span;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 6) == 0) begin
        send_level(1'($urandom_range(0, 1)));
        sent++;
      end else begin
        span = (book.long_ticks > 9) ? 12 :
               int'(book.long_ticks) + ((book.short_ticks > book.long_ticks &&
                                         book.short_ticks < 10) ?
                                        int'(book.short_ticks) - int'(book.long_ticks) : 0) + 3;
        hold = $urandom_range(0, span);
        if ($urandom_range(1, end_odds) == 1)
          gap = int'(book.idle_limit) + $urandom_range(2, 4);
        else
          gap = $urandom_range(1, 3);
        send_run(1'b1, hold + 1);
        send_run(1'b0, gap);
        sent += hold + 1 + gap;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Thresholds as left by reset: a short event and one dot, left pending.
    send_run(1'b0, 1);
    send_run(1'b1, 3);
    send_run(1'b0, 1);

    // Equal thresholds give both events on one tick; a zero idle limit ends quickly.
    set_thresholds(16'd2, 16'd2, 16'd0);
    send_run(1'b1, 4);
    send_run(1'b0, 3);

    // Zero thresholds, then a press released before passing the short threshold.
    set_thresholds(16'd0, 16'd0, 16'd0);
    send_run(1'b1, 2);
    send_run(1'b0, 2);
    send_run(1'b1, 1);
    send_run(1'b0, 1);

    set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_run(1'b1, 2);
    send_run(1'b0, 2);

    set_thresholds(16'd6, 16'd2, 16'd3);
    long_stall_req = 1'b1;
    random_gestures(60, 3);
    set_thresholds(16'd4, 16'd4, 16'd2);
    random_gestures(40, 3);
    // A long idle limit with short gaps lets the symbol store fill up.
    set_thresholds(16'd3, 16'd0, 16'd40);
    random_gestures(100, 25);
    set_thresholds(16'd2, 16'd5, 16'd1);
    random_gestures(40, 3);
    set_thresholds(CFG_W'($urandom_range(0, 8)), CFG_W'($urandom_range(0, 8)),
                   CFG_W'($urandom_range(0, 5)));
    random_gestures(40, 3);

    set_thresholds(16'd5, 16'd1, 16'd2);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    random_gestures(40, 3);
    wait_drained();

    $display("Sent %0d samples under ten threshold settings, with a long stall and a full store.",
             book.levels_taken);
    $display("%0d results: %0d press events, %0d clicks (%0d not stored), %0d sequence symbols.",
             book.results_seen, book.kind_seen[KIND_SHORT] + book.kind_seen[KIND_LONG],
             book.kind_seen[KIND_CLICK], book.full_drops, book.kind_seen[KIND_SEQ]);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #32000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* files.f */
rtl/bpsc_pkg.sv
rtl/bpsc_ram.sv
rtl/bpsc_datapath.sv
rtl/bpsc_ctrl.sv
rtl/button_press_sequence_classifier_unit.sv
rtl/bpsc_checker.sv
test/tb_button_press_sequence_classifier_unit.sv
